// File: hdl/iee_pkg.sv
package iee_pkg;

  localparam int OperatorDepthDefault = 32;
  localparam int OperandDepthDefault  = 32;

  localparam int ValueW = 64;
  localparam int NumW   = 63;
  localparam int OpW    = 3;

  // operator codes
  localparam logic [OpW-1:0] OP_LPAREN = 3'd0;
  localparam logic [OpW-1:0] OP_ADD    = 3'd1;
  localparam logic [OpW-1:0] OP_SUB    = 3'd2;
  localparam logic [OpW-1:0] OP_MUL    = 3'd3;
  localparam logic [OpW-1:0] OP_DIV    = 3'd4;

  localparam logic [NumW-1:0] NUM_MAX = {NumW{1'b1}};

  // request to the arithmetic unit
  typedef struct packed {
    logic            start;
    logic [OpW-1:0]  op;
    logic [ValueW-1:0] a;
    logic [ValueW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] res;
  } alu_rsp_t;

  function automatic logic [1:0] prio(input logic [OpW-1:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    return p;
  endfunction

endpackage

// File: hdl/iee_if.sv
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_byte;
  modport source (output valid, command, char_byte, input ready);
  modport sink   (input valid, command, char_byte, output ready);
endinterface

interface iee_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        error;
  modport source (output valid, value, error, input ready);
  modport sink   (input valid, value, error, output ready);
endinterface

// File: hdl/iee_alu.sv
module iee_alu
  import iee_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int CntW = $clog2(ValueW + 1);

  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [OpW-1:0]    op_r, op_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;   // product or remainder
  logic [ValueW-1:0] sh_r, sh_nxt;     // multiplicand or dividend/quotient
  logic [ValueW-1:0] b_r, b_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [ValueW-1:0] res_r, res_nxt;
  logic [ValueW:0]   rem_sh;
  logic [ValueW:0]   rem_sub;

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  assign rem_sh  = {acc_r, sh_r[ValueW-1]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  // one bit per cycle for multiply and divide; add and subtract need no iteration
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (req.start) begin
      op_nxt  = req.op;
      cnt_nxt = CntW'(ValueW);
      acc_nxt = '0;
      neg_nxt = req.a[ValueW-1] ^ req.b[ValueW-1];
      if (req.op == OP_ADD) begin
        res_nxt  = req.a + req.b;
        done_nxt = 1'b1;
      end else if (req.op == OP_SUB) begin
        res_nxt  = req.a - req.b;
        done_nxt = 1'b1;
      end else if (req.op == OP_MUL) begin
        sh_nxt   = req.a;
        b_nxt    = req.b;
        busy_nxt = 1'b1;
      end else begin
        sh_nxt   = req.a[ValueW-1] ? -req.a : req.a;
        b_nxt    = req.b[ValueW-1] ? -req.b : req.b;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (op_r == OP_MUL) begin
        if (b_r[0]) acc_nxt = acc_r + sh_r;
        sh_nxt = sh_r << 1;
        b_nxt  = b_r >> 1;
        if (cnt_r == CntW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = b_r[0] ? acc_r + sh_r : acc_r;
        end
      end else begin
        if (!rem_sub[ValueW]) begin
          acc_nxt = rem_sub[ValueW-1:0];
          sh_nxt  = {sh_r[ValueW-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh[ValueW-1:0];
          sh_nxt  = {sh_r[ValueW-2:0], 1'b0};
        end
        if (cnt_r == CntW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = neg_r ? -sh_nxt : sh_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

endmodule

// File: hdl/iee_ctrl.sv
module iee_ctrl
  import iee_pkg::*;
#(
  parameter int OPERATOR_DEPTH = OperatorDepthDefault,
  parameter int OPERAND_DEPTH  = OperandDepthDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  iee_in_if.sink   in_ch,
  iee_out_if.source out_ch,
  output alu_req_t req,
  input  alu_rsp_t rsp
);

  localparam int OrAw = $clog2(OPERATOR_DEPTH);
  localparam int OdAw = $clog2(OPERAND_DEPTH);
  localparam int OrCw = $clog2(OPERATOR_DEPTH + 1);
  localparam int OdCw = $clog2(OPERAND_DEPTH + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIGIT  = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_RDOP   = 4'd3;
  localparam logic [3:0] S_RDA    = 4'd4;
  localparam logic [3:0] S_RDB    = 4'd5;
  localparam logic [3:0] S_ALU    = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_RES    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_FLUSH  = 4'd11;

  logic [OpW-1:0]    opr_mem [OPERATOR_DEPTH];
  logic [ValueW-1:0] opd_mem [OPERAND_DEPTH];

  logic [3:0]        st_r, st_nxt;
  logic [OrCw-1:0]   orc_r, orc_nxt;
  logic [OdCw-1:0]   odc_r, odc_nxt;
  logic [NumW-1:0]   num_r, num_nxt;
  logic              innum_r, innum_nxt;
  logic              err_r, err_nxt;
  logic              cmd_r, cmd_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [OpW-1:0]    top_r;
  logic [ValueW-1:0] rd_r;
  logic [ValueW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [OpW-1:0]    aop_r, aop_nxt;
  logic              ovl_r, ovl_nxt;
  logic [ValueW-1:0] oval_r, oval_nxt;
  logic              oerr_r, oerr_nxt;

  logic              opr_we, opd_we;
  logic [OrAw-1:0]   opr_wa, opr_ra;
  logic [OdAw-1:0]   opd_wa, opd_ra;
  logic [OpW-1:0]    opr_wd;
  logic [ValueW-1:0] opd_wd;
  logic [OpW-1:0]    cur_op;
  logic              is_op;
  logic [3:0]        dgt;
  logic [NumW+3:0]   num_x10;

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = ovl_r;
  assign out_ch.value = oval_r;
  assign out_ch.error = oerr_r;

  assign dgt     = ch_r[3:0];
  assign num_x10 = {4'd0, num_r} * (NumW+4)'(10) + (NumW+4)'(dgt);

  // map a character to its operator code
  always_comb begin
    is_op  = 1'b1;
    cur_op = OP_ADD;
    case (ch_r)
      8'h2B:   cur_op = OP_ADD;
      8'h2D:   cur_op = OP_SUB;
      8'h2A:   cur_op = OP_MUL;
      8'h2F:   cur_op = OP_DIV;
      default: is_op = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    orc_nxt   = orc_r;
    odc_nxt   = odc_r;
    num_nxt   = num_r;
    innum_nxt = innum_r;
    err_nxt   = err_r;
    cmd_nxt   = cmd_r;
    ch_nxt    = ch_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    aop_nxt   = aop_r;
    ovl_nxt   = ovl_r;
    oval_nxt  = oval_r;
    oerr_nxt  = oerr_r;
    opr_we    = 1'b0;
    opr_wa    = orc_r[OrAw-1:0];
    opr_wd    = OP_LPAREN;
    opd_we    = 1'b0;
    opd_wa    = odc_r[OdAw-1:0];
    opd_wd    = {1'b0, num_r};
    opr_ra    = OrAw'(orc_r - 1'b1);
    opd_ra    = OdAw'(odc_r - 1'b1);
    req       = '0;
    req.op    = aop_r;
    req.a     = a_r;
    req.b     = b_r;
    if (ovl_r && out_ch.ready) ovl_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          ch_nxt  = in_ch.char_byte;
          if (in_ch.command) st_nxt = S_FLUSH;
          else if (err_r) st_nxt = S_IDLE;
          else if (in_ch.char_byte >= 8'h30 && in_ch.char_byte <= 8'h39) st_nxt = S_DIGIT;
          else st_nxt = S_FLUSH;
        end
      end
      S_DIGIT: begin
        if (!innum_r) num_nxt = NumW'(dgt);
        else if (num_x10[NumW+3:NumW] != '0) num_nxt = NUM_MAX;
        else num_nxt = num_x10[NumW-1:0];
        innum_nxt = 1'b1;
        st_nxt    = S_IDLE;
      end
      S_FLUSH: begin
        // push a pending literal; with an error pending, go straight to the result
        if (err_r) begin
          st_nxt = S_RES;
        end else if (innum_r) begin
          innum_nxt = 1'b0;
          if (odc_r >= OdCw'(OPERAND_DEPTH)) begin
            err_nxt = 1'b1;
            st_nxt  = cmd_r ? S_RES : S_IDLE;
          end else begin
            opd_we  = 1'b1;
            odc_nxt = odc_r + 1'b1;
            st_nxt  = S_DISP;
          end
        end else begin
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (cmd_r) begin
          st_nxt = (orc_r == '0) ? S_RES : S_RDOP;
        end else if (ch_r == 8'h20 || (ch_r >= 8'h09 && ch_r <= 8'h0D)) begin
          st_nxt = S_IDLE;
        end else if (ch_r == 8'h28) begin
          if (orc_r >= OrCw'(OPERATOR_DEPTH)) err_nxt = 1'b1;
          else begin
            opr_we  = 1'b1;
            opr_wd  = OP_LPAREN;
            orc_nxt = orc_r + 1'b1;
          end
          st_nxt = S_IDLE;
        end else if (ch_r == 8'h29 || is_op) begin
          if (orc_r == '0) begin
            if (ch_r == 8'h29) err_nxt = 1'b1;
            else begin
              opr_we  = 1'b1;
              opr_wd  = cur_op;
              orc_nxt = orc_r + 1'b1;
            end
            st_nxt = S_IDLE;
          end else begin
            st_nxt = S_RDOP;
          end
        end else begin
          err_nxt = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_RDOP: begin
        // top operator is in top_r
        aop_nxt = top_r;
        if (cmd_r) begin
          if (top_r == OP_LPAREN) begin
            err_nxt = 1'b1;
            st_nxt  = S_RES;
          end else begin
            st_nxt = S_RDA;
          end
        end else if (ch_r == 8'h29) begin
          if (top_r == OP_LPAREN) begin
            orc_nxt = orc_r - 1'b1;
            st_nxt  = S_IDLE;
          end else begin
            st_nxt = S_RDA;
          end
        end else if (prio(cur_op) <= prio(top_r)) begin
          st_nxt = S_RDA;
        end else begin
          opr_we  = 1'b1;
          opr_wd  = cur_op;
          if (orc_r >= OrCw'(OPERATOR_DEPTH)) err_nxt = 1'b1;
          else orc_nxt = orc_r + 1'b1;
          st_nxt = S_IDLE;
        end
        if (st_nxt == S_RDA) begin
          orc_nxt = orc_r - 1'b1;
          if (odc_r < OdCw'(2)) begin
            err_nxt = 1'b1;
            st_nxt  = cmd_r ? S_RES : S_IDLE;
          end
        end
      end
      S_RDA: begin
        // rd_r holds operand b, fetch a
        b_nxt  = rd_r;
        opd_ra = OdAw'(odc_r - 2'd2);
        st_nxt = S_RDB;
      end
      S_RDB: begin
        // keep operand a on the read port
        opd_ra = OdAw'(odc_r - 2'd2);
        st_nxt = S_ALU;
      end
      S_ALU: begin
        a_nxt = rd_r;
        if (aop_r == OP_DIV && b_r == '0) begin
          err_nxt = 1'b1;
          st_nxt  = cmd_r ? S_RES : S_IDLE;
        end else begin
          req.start = 1'b1;
          req.a     = rd_r;
          st_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rsp.done) begin
          opd_we  = 1'b1;
          opd_wa  = OdAw'(odc_r - 2'd2);
          opd_wd  = rsp.res;
          odc_nxt = odc_r - 1'b1;
          st_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_r) st_nxt = (orc_r == '0) ? S_RES : S_RDOP;
        else if (ch_r == 8'h29) begin
          if (orc_r == '0) begin
            err_nxt = 1'b1;
            st_nxt  = S_IDLE;
          end else st_nxt = S_RDOP;
        end else if (orc_r == '0) begin
          opr_we  = 1'b1;
          opr_wd  = cur_op;
          orc_nxt = orc_r + 1'b1;
          st_nxt  = S_IDLE;
        end else st_nxt = S_RDOP;
      end
      S_RES: begin
        // read the bottom operand
        opd_ra = '0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovl_r || out_ch.ready) begin
          ovl_nxt   = 1'b1;
          if (err_r || odc_r != OdCw'(1)) begin
            oval_nxt = '0;
            oerr_nxt = 1'b1;
          end else begin
            oval_nxt = rd_r;
            oerr_nxt = 1'b0;
          end
          orc_nxt   = '0;
          odc_nxt   = '0;
          innum_nxt = 1'b0;
          err_nxt   = 1'b0;
          num_nxt   = '0;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_RES) opd_ra = '0;
  end

  // stack memories with registered reads
  always_ff @(posedge clk) begin
    if (opr_we) opr_mem[opr_wa] <= opr_wd;
    if (opd_we) opd_mem[opd_wa] <= opd_wd;
    top_r <= opr_mem[opr_ra];
    rd_r  <= opd_mem[opd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      orc_r   <= '0;
      odc_r   <= '0;
      innum_r <= 1'b0;
      err_r   <= 1'b0;
      ovl_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      orc_r   <= orc_nxt;
      odc_r   <= odc_nxt;
      innum_r <= innum_nxt;
      err_r   <= err_nxt;
      ovl_r   <= ovl_nxt;
    end
    num_r  <= num_nxt;
    cmd_r  <= cmd_nxt;
    ch_r   <= ch_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    aop_r  <= aop_nxt;
    oval_r <= oval_nxt;
    oerr_r <= oerr_nxt;
  end

endmodule

// File: hdl/infix_expression_evaluator.sv
// Infix expression evaluator (two-stack shunting-yard).
// Input channel in_*: one word per expression byte (in_command = 0, in_char_byte)
// or an end word (in_command = 1). Result channel out_*: one word per end word,
// carrying out_value (0 on error) and out_error.
// in_ready is high only while the sequencer is idle; a byte is processed in
// full, including every operator it applies, before the next byte is taken.
// * and / run on the bit-serial multiply/divide unit (one bit per cycle), + and
// - without iteration. Unless an error intervenes, an end word applies every pending
// operator before the result is written.
// The result sits in an output register; while out_ready is low the result
// holds and a following end word waits in the last step until it drains.
// Synchronous reset (rst_n low) empties both stacks, clears any pending
// literal and error, and drops out_valid. Stack contents are not cleared.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int OPERATOR_DEPTH = OperatorDepthDefault,
  parameter int OPERAND_DEPTH  = OperandDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic        out_error
);

  iee_in_if  in_ch ();
  iee_out_if out_ch ();
  alu_req_t  req;
  alu_rsp_t  rsp;

  assign in_ch.valid     = in_valid;
  assign in_ch.command   = in_command;
  assign in_ch.char_byte = in_char_byte;
  assign in_ready        = in_ch.ready;
  assign out_valid       = out_ch.valid;
  assign out_ch.ready    = out_ready;
  assign out_value       = out_ch.value;
  assign out_error       = out_ch.error;

  iee_ctrl #(
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .OPERAND_DEPTH  (OPERAND_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .req    (req),
    .rsp    (rsp)
  );

  iee_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule
